@@ rtl/knn_pkg.sv @@
// ----------------------------------------------------------------------------
// knn_pkg
// Shared sizes, codes and types of the k-nearest-neighbor vote classifier.
// ----------------------------------------------------------------------------
package knn_pkg;

  localparam int MaxRows  = 4096;
  localparam int MaxFeat  = 32;
  localparam int MaxNbr   = 16;

  localparam int RowW     = $clog2(MaxRows);
  localparam int FeatW    = $clog2(MaxFeat);
  localparam int AddrW    = RowW + FeatW;
  localparam int RowCntW  = RowW + 1;
  localparam int FeatCntW = FeatW + 1;
  localparam int NbrW     = $clog2(MaxNbr) + 1;
  localparam int ValW     = 16;
  localparam int ProdW    = 32;
  localparam int DistW    = 40;
  localparam int VotesW   = 5;
  localparam int ProbW    = 16;
  localparam int NumW     = VotesW + 15;
  localparam int CfgW     = 13;
  localparam int CfgIdxW  = 2;

  localparam logic FuncLoad  = 1'b0;
  localparam logic FuncQuery = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTrainRows = 2'd0,
    CfgFeatCount = 2'd1,
    CfgNbrCount  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic valid;
    logic last;
    logic zero;
  } knn_tag_t;

endpackage

@@ rtl/knn_store.sv @@
// ----------------------------------------------------------------------------
// knn_store
// Training feature memory, label memory and query feature registers.
// ----------------------------------------------------------------------------
module knn_store (
  input  logic                      clk_i,
  input  logic                      wr_train_i,
  input  logic                      wr_query_i,
  input  logic [knn_pkg::RowW-1:0]  wr_row_i,
  input  logic [knn_pkg::FeatW-1:0] wr_feat_i,
  input  logic [knn_pkg::ValW-1:0]  wr_val_i,
  input  logic                      wr_label_i,
  input  logic                      rd_en_i,
  input  logic [knn_pkg::RowW-1:0]  rd_row_i,
  input  logic [knn_pkg::FeatW-1:0] rd_feat_i,
  output logic [knn_pkg::ValW-1:0]  train_val_o,
  output logic [knn_pkg::ValW-1:0]  query_val_o,
  output logic                      label_o
);
  import knn_pkg::*;

  logic [ValW-1:0] train_mem [MaxRows*MaxFeat];
  logic            label_mem [MaxRows];
  logic [ValW-1:0] query_mem [MaxFeat];

  always_ff @(posedge clk_i) begin
    if (wr_train_i) begin
      train_mem[{wr_row_i, wr_feat_i}] <= wr_val_i;
    end
    if (rd_en_i) begin
      train_val_o <= train_mem[{rd_row_i, rd_feat_i}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_train_i) begin
      label_mem[wr_row_i] <= wr_label_i;
    end
    if (rd_en_i) begin
      label_o <= label_mem[rd_row_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_query_i) begin
      query_mem[wr_feat_i] <= wr_val_i;
    end
    if (rd_en_i) begin
      query_val_o <= query_mem[rd_feat_i];
    end
  end

endmodule

@@ rtl/knn_dist.sv @@
// ----------------------------------------------------------------------------
// knn_dist
// Shared square-and-accumulate unit: one feature difference per cycle.
// ----------------------------------------------------------------------------
module knn_dist (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  knn_pkg::knn_tag_t         tag_i,
  input  logic [knn_pkg::ValW-1:0]  train_val_i,
  input  logic [knn_pkg::ValW-1:0]  query_val_i,
  input  logic                      label_i,
  output logic                      ins_valid_o,
  output logic [knn_pkg::DistW-1:0] ins_dist_o,
  output logic                      ins_label_o,
  output logic                      busy_o
);
  import knn_pkg::*;

  logic signed [ValW:0]    diff;
  logic signed [2*ValW+1:0] sq;
  logic [ProdW-1:0]        prod_d, prod_q;
  knn_tag_t                tag_q;
  logic                    label_q;
  logic [DistW-1:0]        acc_q, sum;

  assign diff   = $signed({query_val_i[ValW-1], query_val_i})
                - $signed({train_val_i[ValW-1], train_val_i});
  assign sq     = diff * diff;
  assign prod_d = tag_i.zero ? '0 : sq[ProdW-1:0];
  assign sum    = acc_q + {{(DistW-ProdW){1'b0}}, prod_q};

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    label_q <= label_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q       <= '0;
      acc_q       <= '0;
      ins_valid_o <= 1'b0;
      ins_dist_o  <= '0;
      ins_label_o <= 1'b0;
    end else begin
      tag_q       <= tag_i;
      ins_valid_o <= tag_q.valid & tag_q.last;
      if (tag_q.valid) begin
        if (tag_q.last) begin
          ins_dist_o  <= sum;
          ins_label_o <= label_q;
          acc_q       <= '0;
        end else begin
          acc_q <= sum;
        end
      end
    end
  end

  assign busy_o = tag_q.valid | ins_valid_o;

endmodule

@@ rtl/knn_topk.sv @@
// ----------------------------------------------------------------------------
// knn_topk
// Sorted list of the nearest (distance, label) pairs with shift insertion.
// ----------------------------------------------------------------------------
module knn_topk (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       clear_i,
  input  logic                       ins_valid_i,
  input  logic [knn_pkg::DistW-1:0]  dist_i,
  input  logic                       label_i,
  input  logic [knn_pkg::NbrW-1:0]   k_i,
  output logic [knn_pkg::VotesW-1:0] votes_o
);
  import knn_pkg::*;

  logic [DistW-1:0] dist_q [MaxNbr];
  logic             lab_q  [MaxNbr];
  logic [MaxNbr-1:0] closer;

  always_comb begin
    for (int i = 0; i < MaxNbr; i++) begin
      closer[i] = (dist_i < dist_q[i]) || ((dist_i == dist_q[i]) && !label_i && lab_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxNbr; i++) begin
        dist_q[i] <= '1;
        lab_q[i]  <= 1'b0;
      end
    end else if (clear_i) begin
      for (int i = 0; i < MaxNbr; i++) begin
        dist_q[i] <= '1;
        lab_q[i]  <= 1'b0;
      end
    end else if (ins_valid_i) begin
      for (int i = 0; i < MaxNbr; i++) begin
        if (closer[i]) begin
          if (i > 0 && closer[(i > 0) ? i-1 : 0]) begin
            dist_q[i] <= dist_q[(i > 0) ? i-1 : 0];
            lab_q[i]  <= lab_q[(i > 0) ? i-1 : 0];
          end else begin
            dist_q[i] <= dist_i;
            lab_q[i]  <= label_i;
          end
        end
      end
    end
  end

  always_comb begin
    votes_o = '0;
    for (int i = 0; i < MaxNbr; i++) begin
      if (NbrW'(i) < k_i && lab_q[i]) begin
        votes_o = votes_o + VotesW'(1);
      end
    end
  end

endmodule

@@ rtl/knn_div.sv @@
// ----------------------------------------------------------------------------
// knn_div
// Restoring divider, one quotient bit per cycle, for the vote fraction.
// ----------------------------------------------------------------------------
module knn_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [knn_pkg::NumW-1:0]   num_i,
  input  logic [knn_pkg::NbrW-1:0]   den_i,
  output logic                       done_o,
  output logic [knn_pkg::ProbW-1:0]  quot_o
);
  import knn_pkg::*;

  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] num_q;
  logic [NbrW:0]   rem_q, rem_sh;
  logic [NbrW-1:0] den_q;
  logic [CntW-1:0] cnt_q;
  logic            run_q;

  assign rem_sh = {rem_q[NbrW-1:0], num_q[NumW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
      num_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
    end else begin
      done_o <= run_q && !start_i && (cnt_q == CntW'(NumW - 1));
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
        num_q <= num_i;
        rem_q <= '0;
        den_q <= den_i;
      end else if (run_q) begin
        if (rem_sh >= {1'b0, den_q}) begin
          rem_q <= rem_sh - {1'b0, den_q};
          num_q <= {num_q[NumW-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          num_q <= {num_q[NumW-2:0], 1'b0};
        end
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(NumW - 1)) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  assign quot_o = num_q[ProbW-1:0];

endmodule

@@ rtl/knn_vote_classifier.sv @@
// ----------------------------------------------------------------------------
// knn_vote_classifier
// Binary k-nearest-neighbor classifier with majority vote.
// ----------------------------------------------------------------------------
// Load and query items transfer one per cycle while the block is idle. A
// query item with tlast starts the search, and no item is taken until the
// result is in the output register. The search is set by the single
// square-and-accumulate unit, which reads one stored feature per cycle from
// the training memory for every feature of every row (one read per row when
// the feature count is zero), and ends with the bit-serial divider. A result
// still waiting in the output register holds the block until it transfers.
// Stores hold no defined value until written; no clearing pass runs after reset.
module knn_vote_classifier (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // row_index[11:0], feature_index[16:12], feature_value[32:17],
  // class_label[33], zero fill
  input  logic [39:0]                 s_axis_tdata,
  // func
  input  logic                        s_axis_tuser,
  input  logic                        s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // positive_votes[4:0], probability[20:5], zero fill
  output logic [23:0]                 m_axis_tdata,
  input  logic                        cfg_we_i,
  input  logic [knn_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [knn_pkg::CfgW-1:0]    cfg_wdata_i
);
  import knn_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StRun,
    StDrain,
    StDiv,
    StHold
  } state_e;

  state_e state_q;

  logic [RowCntW-1:0]  cfg_rows_q, rows_eff, rows_q, row_q;
  logic [FeatCntW-1:0] cfg_feat_q, nf_eff, nf_q, feat_q;
  logic [NbrW-1:0]     cfg_nbr_q, k_sat, k_eff, k_q;

  logic                s_xfer, start, issue_last;
  logic [RowW-1:0]     in_row;
  logic [FeatW-1:0]    in_feat;
  logic [ValW-1:0]     in_val;
  logic                in_label;

  knn_tag_t            tag_d, tag_q;
  logic [ValW-1:0]     train_val, query_val;
  logic                label_rd;
  logic                ins_valid, ins_label, dist_busy;
  logic [DistW-1:0]    ins_dist;
  logic [VotesW-1:0]   votes, votes_q;
  logic                div_start, div_done;
  logic [ProbW-1:0]    quot;
  logic [NumW-1:0]     div_num;

  assign in_row   = s_axis_tdata[11:0];
  assign in_feat  = s_axis_tdata[16:12];
  assign in_val   = s_axis_tdata[32:17];
  assign in_label = s_axis_tdata[33];

  assign s_axis_tready = (state_q == StIdle);
  assign s_xfer        = s_axis_tvalid & s_axis_tready;
  assign start         = s_xfer & (s_axis_tuser == FuncQuery) & s_axis_tlast;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_rows_q <= RowCntW'(MaxRows);
      cfg_feat_q <= FeatCntW'(20);
      cfg_nbr_q  <= NbrW'(5);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgTrainRows: cfg_rows_q <= cfg_wdata_i[RowCntW-1:0];
        CfgFeatCount: cfg_feat_q <= cfg_wdata_i[FeatCntW-1:0];
        CfgNbrCount:  cfg_nbr_q  <= cfg_wdata_i[NbrW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rows_eff = cfg_rows_q;
    if (cfg_rows_q == '0) begin
      rows_eff = RowCntW'(1);
    end else if (cfg_rows_q > RowCntW'(MaxRows)) begin
      rows_eff = RowCntW'(MaxRows);
    end
    nf_eff = (cfg_feat_q > FeatCntW'(MaxFeat)) ? FeatCntW'(MaxFeat) : cfg_feat_q;
    k_sat  = (cfg_nbr_q > NbrW'(MaxNbr)) ? NbrW'(MaxNbr) : cfg_nbr_q;
    k_eff  = ({{(RowCntW-NbrW){1'b0}}, k_sat} > rows_eff) ? rows_eff[NbrW-1:0] : k_sat;
    if (k_eff == '0) begin
      k_eff = NbrW'(1);
    end
  end

  assign issue_last = (nf_q == '0) || (feat_q == nf_q - FeatCntW'(1));

  always_comb begin
    tag_d       = '0;
    tag_d.valid = (state_q == StRun);
    tag_d.last  = issue_last;
    tag_d.zero  = (nf_q == '0);
  end

  assign div_num   = {votes_q, 15'd0} + {{(NumW-NbrW+1){1'b0}}, k_q[NbrW-1:1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      tag_q         <= '0;
      rows_q        <= '0;
      nf_q          <= '0;
      k_q           <= NbrW'(1);
      row_q         <= '0;
      feat_q        <= '0;
      votes_q       <= '0;
      div_start     <= 1'b0;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata  <= '0;
    end else begin
      tag_q     <= tag_d;
      div_start <= (state_q == StDrain) && !tag_q.valid && !dist_busy;
      if ((state_q == StHold) && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (start) begin
            rows_q  <= rows_eff;
            nf_q    <= nf_eff;
            k_q     <= k_eff;
            row_q   <= '0;
            feat_q  <= '0;
            state_q <= StRun;
          end
        end
        StRun: begin
          if (issue_last) begin
            feat_q <= '0;
            row_q  <= row_q + RowCntW'(1);
            if (row_q == rows_q - RowCntW'(1)) begin
              state_q <= StDrain;
            end
          end else begin
            feat_q <= feat_q + FeatCntW'(1);
          end
        end
        StDrain: begin
          if (!tag_q.valid && !dist_busy) begin
            votes_q <= votes;
            state_q <= StDiv;
          end
        end
        StDiv: begin
          if (div_done) begin
            state_q <= StHold;
          end
        end
        StHold: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata <= {3'd0, quot, votes_q};
            state_q      <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  knn_store u_store (
    .clk_i       (clk_i),
    .wr_train_i  (s_xfer && (s_axis_tuser == FuncLoad)),
    .wr_query_i  (s_xfer && (s_axis_tuser == FuncQuery)),
    .wr_row_i    (in_row),
    .wr_feat_i   (in_feat),
    .wr_val_i    (in_val),
    .wr_label_i  (in_label),
    .rd_en_i     (state_q == StRun),
    .rd_row_i    (row_q[RowW-1:0]),
    .rd_feat_i   (feat_q[FeatW-1:0]),
    .train_val_o (train_val),
    .query_val_o (query_val),
    .label_o     (label_rd)
  );

  knn_dist u_dist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tag_i       (tag_q),
    .train_val_i (train_val),
    .query_val_i (query_val),
    .label_i     (label_rd),
    .ins_valid_o (ins_valid),
    .ins_dist_o  (ins_dist),
    .ins_label_o (ins_label),
    .busy_o      (dist_busy)
  );

  knn_topk u_topk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (start),
    .ins_valid_i (ins_valid),
    .dist_i      (ins_dist),
    .label_i     (ins_label),
    .k_i         (k_q),
    .votes_o     (votes)
  );

  knn_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (k_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

endmodule

@@ rtl/knn_checker.sv @@
// ----------------------------------------------------------------------------
// knn_checker
// Port-level checks of the classifier result stream.
// ----------------------------------------------------------------------------
module knn_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[4:0] <= 5'd16) && (m_axis_tdata[20:5] <= 16'd32768))
    else $error("result out of range");

  a_zero_votes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[4:0] == 5'd0) == (m_axis_tdata[20:5] == 16'd0)))
    else $error("probability disagrees with vote count");

  a_busy_after_trigger: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !$past(m_axis_tvalid) |-> !$past(s_axis_tready, 2))
    else $error("result appeared without a search");

endmodule

bind knn_vote_classifier knn_checker u_knn_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
